### hdl/rcenc_pkg.sv
// Shared widths, codes and pattern constants of the RC5/RC6 infrared burst encoder.
`timescale 1ns / 1ps
`default_nettype none

package rcenc_pkg;

	// Half-bit pattern store and the run counting over it
	localparam int HALF_BITS = 128;
	localparam int CNT_GROUP = 8;
	localparam int CNT_STEPS = HALF_BITS / CNT_GROUP;
	localparam int CNT_W     = $clog2(CNT_STEPS);
	localparam int RISE_W    = $clog2(CNT_GROUP + 1);
	localparam int ITEM_W    = $clog2(HALF_BITS / 2 + 1);

	// At most this many pairs follow the header beat
	localparam int MAX_PAIRS = 43;
	localparam int PAIR_W    = $clog2(MAX_PAIRS + 1);

	// Field widths
	localparam int ACT_W    = 2;
	localparam int SYS_W    = 8;
	localparam int CMD_W    = 8;
	localparam int DATA_W   = 6;
	localparam int CUST_W   = 16;
	localparam int KIND_W   = 2;
	localparam int WORD_W   = 16;
	localparam int STAT_W   = 3;
	localparam int UNIT_W   = 12;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	// Time accumulator: a full pattern of one run times the widest unit fits
	localparam int ACC_W = UNIT_W + $clog2(HALF_BITS + 1);

	// Protocol codes
	localparam logic [ACT_W-1:0] ACT_RC5  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_RC5X = 2'd1;
	localparam logic [ACT_W-1:0] ACT_RC6  = 2'd2;
	localparam logic [ACT_W-1:0] ACT_RC6A = 2'd3;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_HEAD = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PAIR = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;

	// Status codes; the data field cannot be out of range at its width
	localparam logic [STAT_W-1:0] STAT_OK   = 3'd0;
	localparam logic [STAT_W-1:0] STAT_SYS  = 3'd1;
	localparam logic [STAT_W-1:0] STAT_CMD  = 3'd2;
	localparam logic [STAT_W-1:0] STAT_CUST = 3'd4;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LONG    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CARRIER = 2'd3;

	// Register reset values
	localparam logic [UNIT_W-1:0] LONG_RST  = 12'd32;
	localparam logic [UNIT_W-1:0] SHORT_RST = 12'd16;
	localparam logic [WORD_W-1:0] GAP_RST   = 16'd2484;

	// Range limits
	localparam logic [SYS_W-1:0]  RC5_SYS_MAX  = 8'd31;
	localparam logic [CMD_W-1:0]  RC5_CMD_MAX  = 8'd127;
	localparam logic [CUST_W-1:0] CUST_SHORT_MAX = 16'd127;
	localparam logic [CUST_W-1:0] CUST_LONG_MIN  = 16'd32768;

	// Fixed RC6 and RC6A leaders, sent MSB first
	localparam logic [15:0] RC6_HDR  = 16'b1111110010010101;
	localparam logic [17:0] RC6A_HDR = 18'b011111110010101001;

endpackage

`default_nettype wire

### hdl/rcenc_cmd_if.sv
// Command channel: one infrared command per beat.
`timescale 1ns / 1ps
`default_nettype none

interface rcenc_cmd_if;
	import rcenc_pkg::*;

	logic               valid;
	logic               ready;
	logic [ACT_W-1:0]   action;
	logic               toggle;
	logic [SYS_W-1:0]   system_addr;
	logic [CMD_W-1:0]   command_code;
	logic [DATA_W-1:0]  data_bits;
	logic [CUST_W-1:0]  customer_id;
	logic               repeat_req;

	modport source (
		output valid, action, toggle, system_addr, command_code, data_bits,
			customer_id, repeat_req,
		input  ready
	);

	modport sink (
		input  valid, action, toggle, system_addr, command_code, data_bits,
			customer_id, repeat_req,
		output ready
	);
endinterface

`default_nettype wire

### hdl/rcenc_res_if.sv
// Result channel: header, burst pair or error per beat.
`timescale 1ns / 1ps
`default_nettype none

interface rcenc_res_if;
	import rcenc_pkg::*;

	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [WORD_W-1:0]  word_a;
	logic [WORD_W-1:0]  word_b;
	logic [STAT_W-1:0]  status;
	logic               last;

	modport source (
		output valid, kind, word_a, word_b, status, last,
		input  ready
	);

	modport sink (
		input  valid, kind, word_a, word_b, status, last,
		output ready
	);
endinterface

`default_nettype wire

### hdl/rc5_rc6_ir_burst_encoder.sv
// Top level of the RC5/RC5X/RC6/RC6A infrared burst encoder.
`timescale 1ns / 1ps
`default_nettype none

// Takes one infrared command per cmd beat and answers on res with either a
// single error beat (first bad field wins, last set) or a header beat with the
// pair count in word_a (once) or word_b (repeat), followed by on/off pairs in
// carrier cycles; the last pair carries the gap as its off time and has last
// set. Words saturate at 65535. A good command is loaded into a 128 half-bit
// shift register, then a counting pass walks it eight half bits a cycle to
// find the pair count, then the header is sent, then one half bit per cycle
// goes through a single shared time adder, except while a pair waits for a
// free output register, until the rest of the pattern is all off, then the
// final pair is closed. cmd.ready is high only while the encoder is idle and
// its output register is free. Write configuration only while the encoder is
// idle; the carrier word is accepted but no result carries it.
module rc5_rc6_ir_burst_encoder (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [rcenc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rcenc_pkg::CFG_DAT_W-1:0] cfg_wdata,
	rcenc_cmd_if.sink                           cmd,
	rcenc_res_if.source                         res
);
	import rcenc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_COUNT = 4'b0010,
		ST_HEAD  = 4'b0100,
		ST_SCAN  = 4'b1000
	} state_t;

	// Biphase coding of up to 16 bits, MSB first; rc5 picks 0 = 10, 1 = 01,
	// otherwise the inverted form 0 = 01, 1 = 10.
	function automatic logic [31:0] biphase16(input logic [15:0] v, input logic rc5);
		logic [31:0] r;
		for (int i = 0; i < 16; i++) begin
			r[2*i +: 2] = {v[i] ^ rc5, ~v[i] ^ rc5};
		end
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] sat16(input logic [ACC_W-1:0] v);
		if (v > ACC_W'(16'hFFFF)) begin
			return 16'hFFFF;
		end
		return v[WORD_W-1:0];
	endfunction

	state_t                  state_q;
	logic [HALF_BITS-1:0]    pat_q;
	logic [UNIT_W-1:0]       unit_q;
	logic                    rep_q;
	logic [ITEM_W-1:0]       items_q;
	logic                    prev_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    seen_q;
	logic                    in_off_q;
	logic [ACC_W-1:0]        on_q;
	logic [ACC_W-1:0]        off_q;
	logic [PAIR_W-1:0]       pc_q;

	logic [UNIT_W-1:0]       long_q;
	logic [UNIT_W-1:0]       short_q;
	logic [WORD_W-1:0]       gap_q;

	logic                    res_valid_q;
	logic [KIND_W-1:0]       kind_q;
	logic [WORD_W-1:0]       word_a_q;
	logic [WORD_W-1:0]       word_b_q;
	logic [STAT_W-1:0]       status_q;
	logic                    last_q;

	logic                    out_free;
	logic                    cmd_take;
	logic [STAT_W-1:0]       chk_status;
	logic [HALF_BITS-1:0]    pat_new;
	logic [CNT_GROUP-1:0]    grp;
	logic [RISE_W-1:0]       rise_n;
	logic [ACC_W-1:0]        acc_sum;
	logic                    cur_bit;
	logic                    pat_empty;

	assign out_free = !res_valid_q || res.ready;
	assign cmd.ready = (state_q == ST_IDLE) && out_free;
	assign cmd_take = cmd.valid && cmd.ready;

	assign res.valid  = res_valid_q;
	assign res.kind   = kind_q;
	assign res.word_a = word_a_q;
	assign res.word_b = word_b_q;
	assign res.status = status_q;
	assign res.last   = last_q;

	// Check field ranges in order
	always_comb begin
		chk_status = STAT_OK;
		if (cmd.action == ACT_RC5 || cmd.action == ACT_RC5X) begin
			if (cmd.system_addr > RC5_SYS_MAX) begin
				chk_status = STAT_SYS;
			end else if (cmd.command_code > RC5_CMD_MAX) begin
				chk_status = STAT_CMD;
			end
		end else if (cmd.action == ACT_RC6A) begin
			if (cmd.customer_id > CUST_SHORT_MAX && cmd.customer_id < CUST_LONG_MIN) begin
				chk_status = STAT_CUST;
			end
		end
	end

	// Build the half-bit pattern, left aligned and zero filled
	always_comb begin
		logic [31:0] m5_lead;
		logic [31:0] m5_sys;
		logic [31:0] m5_cmd;
		logic [31:0] m5_dat;
		logic [31:0] m6_sys;
		logic [31:0] m6_cmd;
		logic [31:0] m6_short;
		logic [31:0] m6_long;
		logic [3:0]  tog4;
		m5_lead  = biphase16({13'd0, 1'b1, ~cmd.command_code[6], cmd.toggle}, 1'b1);
		m5_sys   = biphase16({8'd0, cmd.system_addr}, 1'b1);
		m5_cmd   = biphase16({10'd0, cmd.command_code[5:0]}, 1'b1);
		m5_dat   = biphase16({10'd0, cmd.data_bits}, 1'b1);
		m6_sys   = biphase16({8'd0, cmd.system_addr}, 1'b0);
		m6_cmd   = biphase16({8'd0, cmd.command_code}, 1'b0);
		m6_short = biphase16({8'd0, 1'b0, cmd.customer_id[6:0]}, 1'b0);
		m6_long  = biphase16({1'b1, cmd.customer_id[14:0]}, 1'b0);
		tog4     = {cmd.toggle, cmd.toggle, ~cmd.toggle, ~cmd.toggle};
		case (cmd.action)
			ACT_RC5: begin
				pat_new = {m5_lead[5:0], m5_sys[9:0], m5_cmd[11:0],
					{(HALF_BITS - 28){1'b0}}};
			end
			ACT_RC5X: begin
				pat_new = {m5_lead[5:0], m5_sys[9:0], 4'b0000, m5_cmd[11:0],
					m5_dat[11:0], {(HALF_BITS - 44){1'b0}}};
			end
			ACT_RC6: begin
				pat_new = {RC6_HDR, tog4, m6_sys[15:0], m6_cmd[15:0],
					{(HALF_BITS - 52){1'b0}}};
			end
			ACT_RC6A: begin
				if (cmd.customer_id[15]) begin
					pat_new = {RC6A_HDR, tog4, m6_long, m6_sys[15:0], m6_cmd[15:0],
						{(HALF_BITS - 86){1'b0}}};
				end else begin
					pat_new = {RC6A_HDR, tog4, m6_short[15:0], m6_sys[15:0],
						m6_cmd[15:0], {(HALF_BITS - 70){1'b0}}};
				end
			end
			default: begin
				pat_new = '0;
			end
		endcase
	end

	// Count rising edges in the top group of the pattern
	assign grp = pat_q[HALF_BITS-1 -: CNT_GROUP];
	always_comb begin
		rise_n = '0;
		for (int j = 0; j < CNT_GROUP; j++) begin
			if (j == CNT_GROUP - 1) begin
				rise_n = rise_n + RISE_W'(grp[j] & ~prev_q);
			end else begin
				rise_n = rise_n + RISE_W'(grp[j] & ~grp[j+1]);
			end
		end
	end

	// Shared time adder: grow the run that is open
	assign acc_sum   = (in_off_q ? off_q : on_q) + ACC_W'(unit_q);
	assign cur_bit   = pat_q[HALF_BITS-1];
	assign pat_empty = (pat_q == '0);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_q  <= LONG_RST;
			short_q <= SHORT_RST;
			gap_q   <= GAP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LONG:    long_q  <= cfg_wdata[UNIT_W-1:0];
				CFG_SHORT:   short_q <= cfg_wdata[UNIT_W-1:0];
				CFG_GAP:     gap_q   <= cfg_wdata;
				CFG_CARRIER: ;
				default:     ;
			endcase
		end
	end

	// Sequencer control and the output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_take) begin
						if (chk_status != STAT_OK) begin
							res_valid_q <= 1'b1;
						end else begin
							state_q <= ST_COUNT;
						end
					end
				end
				ST_COUNT: begin
					if (cnt_q == CNT_W'(CNT_STEPS - 1)) begin
						state_q <= ST_HEAD;
					end
				end
				ST_HEAD: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (pat_empty) begin
						if (out_free) begin
							res_valid_q <= 1'b1;
							state_q     <= ST_IDLE;
						end
					end else if (seen_q && in_off_q && cur_bit && out_free) begin
						res_valid_q <= 1'b1;
						if (pc_q == PAIR_W'(MAX_PAIRS - 1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Pattern, counters, run times and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd_take) begin
					kind_q   <= KIND_ERR;
					word_a_q <= '0;
					word_b_q <= '0;
					status_q <= chk_status;
					last_q   <= 1'b1;
					pat_q    <= pat_new;
					unit_q   <= (cmd.action == ACT_RC5 || cmd.action == ACT_RC5X) ?
						long_q : short_q;
					rep_q    <= cmd.repeat_req;
					items_q  <= '0;
					prev_q   <= 1'b0;
					cnt_q    <= '0;
				end
			end
			ST_COUNT: begin
				// Rotate, so the pattern is whole again after the pass
				items_q <= items_q + ITEM_W'(rise_n);
				prev_q  <= grp[0];
				pat_q   <= {pat_q[HALF_BITS-CNT_GROUP-1:0], grp};
				cnt_q   <= cnt_q + CNT_W'(1);
			end
			ST_HEAD: begin
				if (out_free) begin
					kind_q   <= KIND_HEAD;
					word_a_q <= rep_q ? '0 : WORD_W'(items_q);
					word_b_q <= rep_q ? WORD_W'(items_q) : '0;
					status_q <= STAT_OK;
					last_q   <= 1'b0;
					seen_q   <= 1'b0;
					in_off_q <= 1'b0;
					pc_q     <= '0;
				end
			end
			ST_SCAN: begin
				if (pat_empty) begin
					// Close the final pair with the gap
					if (out_free) begin
						kind_q   <= KIND_PAIR;
						word_a_q <= sat16(on_q);
						word_b_q <= gap_q;
						status_q <= STAT_OK;
						last_q   <= 1'b1;
					end
				end else if (!seen_q) begin
					// Drop leading off half bits
					if (cur_bit) begin
						seen_q <= 1'b1;
						on_q   <= ACC_W'(unit_q);
					end
					pat_q <= {pat_q[HALF_BITS-2:0], 1'b0};
				end else if (!in_off_q) begin
					if (cur_bit) begin
						on_q <= acc_sum;
					end else begin
						in_off_q <= 1'b1;
						off_q    <= ACC_W'(unit_q);
					end
					pat_q <= {pat_q[HALF_BITS-2:0], 1'b0};
				end else if (!cur_bit) begin
					off_q <= acc_sum;
					pat_q <= {pat_q[HALF_BITS-2:0], 1'b0};
				end else if (out_free) begin
					// A new on run closes the pair: send it and open the next
					kind_q   <= KIND_PAIR;
					word_a_q <= sat16(on_q);
					word_b_q <= sat16(off_q);
					status_q <= STAT_OK;
					last_q   <= 1'b0;
					pc_q     <= pc_q + PAIR_W'(1);
					on_q     <= ACC_W'(unit_q);
					in_off_q <= 1'b0;
					pat_q    <= {pat_q[HALF_BITS-2:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	// Error beats stand alone and end the command
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.kind == KIND_ERR |-> res.last && res.status != STAT_OK)
		else $error("error beat without last or with ok status");

	// Header carries the count in exactly one of its words
	a_head_words: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.kind == KIND_HEAD |->
			!res.last && res.status == STAT_OK && (res.word_a == '0 || res.word_b == '0))
		else $error("malformed header beat");

	// Pair count never passes the limit while scanning
	a_pair_limit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> pc_q < PAIR_W'(MAX_PAIRS))
		else $error("pair count past limit");

	// A final beat taken with the sequencer idle and no new command leaves it ready
	a_back_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.ready && res.last && state_q == ST_IDLE && !cmd_take |=> cmd.ready)
		else $error("encoder not ready after final beat");

endmodule

`default_nettype wire
